### design/decimal128_integer_rounding_unit_assert.svh
// Assertion macros for the decimal128 integer rounding unit.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DECIMAL128_INTEGER_ROUNDING_UNIT_ASSERT_SVH
`define DECIMAL128_INTEGER_ROUNDING_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D128R_CHECK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define D128R_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/d128r_pkg.sv
// Shared types and constants of the decimal128 integer rounding unit.
// No dependencies; used by the divide-by-ten unit, the top level and the testbench.
package d128r_pkg;

    localparam int MAX_SCALE_DEF = 28;
    localparam int MAG_W         = 96;
    localparam int LIMB_W        = 24;
    localparam int LIMB_N        = MAG_W / LIMB_W;
    localparam int LIMB_CW       = $clog2(LIMB_N);
    localparam int REM_W         = 4;
    localparam int SCALE_W       = 5;
    localparam int NUM_W         = REM_W + LIMB_W;
    localparam int RECIP_SHIFT   = 32;
    localparam int RECIP_W       = 29;
    localparam logic [RECIP_W-1:0] RECIP_TEN  = 29'd429496730;
    localparam logic [REM_W-1:0]   ROUND_HALF = 4'd5;

    typedef enum logic [1:0] {
        OP_NEGATE   = 2'd0,
        OP_TRUNCATE = 2'd1,
        OP_FLOOR    = 2'd2,
        OP_ROUND    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl;

endpackage

### design/d128r_div10.sv
// Divide-by-ten unit for one 24-bit limb with the running remainder on top.
// Uses a reciprocal multiply; depends on d128r_pkg.
module d128r_div10 import d128r_pkg::*; (
    input  logic [REM_W-1:0]  i_rem,
    input  logic [LIMB_W-1:0] i_limb,
    output logic [LIMB_W-1:0] o_quot,
    output logic [REM_W-1:0]  o_rem
);

    logic [NUM_W-1:0]           num;
    logic [NUM_W+RECIP_W-1:0]   prod;
    logic [NUM_W-1:0]           quot_full;
    logic [NUM_W-1:0]           rem_full;

    // The reciprocal is exact for every numerator below 2^28.
    assign num       = {i_rem, i_limb};
    assign prod      = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(RECIP_TEN);
    assign quot_full = NUM_W'(prod >> RECIP_SHIFT);
    assign rem_full  = num - {quot_full[NUM_W-4:0], 3'b000} - {quot_full[NUM_W-2:0], 1'b0};
    assign o_quot    = quot_full[LIMB_W-1:0];
    assign o_rem     = rem_full[REM_W-1:0];

endmodule

### design/decimal128_integer_rounding_unit.sv
// Top level of the decimal128 integer rounding unit: sequencer and datapath.
// Depends on d128r_pkg, d128r_div10 and the assertion macro header.
//
// One operation is taken when i_start is high while o_busy is low. Negate, an
// invalid scale and a scale of zero go from idle straight to the finish state;
// otherwise the magnitude passes 4 times per scale step through a single 24-bit
// limb divide-by-ten unit in the divide state. The finish state registers the
// result, which stays on the o_result_* ports until the next result; o_done marks
// it for exactly one cycle, and the receiver cannot stall it;
// a new operation may be started in the same cycle that o_done is high.
`include "decimal128_integer_rounding_unit_assert.svh"

module decimal128_integer_rounding_unit import d128r_pkg::*; #(
    parameter int MAX_SCALE = MAX_SCALE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_operation,
    input  logic [63:0]        i_magnitude_low,
    input  logic [31:0]        i_magnitude_high,
    input  logic [7:0]         i_scale,
    input  logic               i_negative,
    output logic               o_done,
    output logic [63:0]        o_result_magnitude_low,
    output logic [31:0]        o_result_magnitude_high,
    output logic [SCALE_W-1:0] o_result_scale,
    output logic               o_result_negative,
    output logic               o_error
);

    localparam int CNT_W = $clog2(MAX_SCALE + 1);

    t_state             r_state;
    t_state             n_state;
    t_ctrl              ctrl;
    t_op                r_op;
    logic               r_neg;
    logic               r_err;
    logic [SCALE_W-1:0] r_scale;
    logic [MAG_W-1:0]   r_orig;
    logic [MAG_W-1:0]   r_work;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_last_rem;
    logic               r_sticky;
    logic [CNT_W-1:0]   r_digits;
    logic [LIMB_CW-1:0] r_limb;
    logic               r_done;
    logic [MAG_W-1:0]   r_res_mag;
    logic [SCALE_W-1:0] r_res_scale;
    logic               r_res_neg;
    logic               r_res_err;

    logic               in_err;
    logic               go_div;
    logic               limb_last;
    logic [LIMB_W-1:0]  div_quot;
    logic [REM_W-1:0]   div_rem;
    logic [MAG_W-1:0]   inc_sum;
    logic [MAG_W-1:0]   fin_mag;
    logic [SCALE_W-1:0] fin_scale;
    logic               fin_neg;

    assign in_err    = i_scale > 8'(MAX_SCALE);
    assign go_div    = !in_err && (i_scale != 8'd0) && (t_op'(i_operation) != OP_NEGATE);
    assign limb_last = r_limb == LIMB_CW'(LIMB_N - 1);

    d128r_div10 u_div10 (
        .i_rem  (r_rem),
        .i_limb (r_work[MAG_W-1 -: LIMB_W]),
        .o_quot (div_quot),
        .o_rem  (div_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = go_div ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                if (limb_last && r_digits == CNT_W'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (r_state)
            S_IDLE:  ctrl.load   = i_start;
            S_DIV:   ctrl.step   = 1'b1;
            S_FIN:   ctrl.finish = 1'b1;
            default: ctrl        = '0;
        endcase
    end

    assign inc_sum = r_work + MAG_W'(1);

    always_comb begin
        fin_mag   = '0;
        fin_scale = '0;
        fin_neg   = 1'b0;
        if (r_err) begin
            if (r_op == OP_TRUNCATE) begin
                fin_neg = r_neg;
            end else if (r_op == OP_NEGATE) begin
                fin_neg = !r_neg;
            end
        end else begin
            case (r_op)
                OP_NEGATE: begin
                    fin_mag   = r_orig;
                    fin_scale = r_scale;
                    fin_neg   = !r_neg;
                end
                OP_TRUNCATE: begin
                    fin_mag = r_work;
                    fin_neg = r_neg;
                end
                OP_FLOOR: begin
                    if (!r_sticky) begin
                        fin_mag   = r_orig;
                        fin_scale = r_scale;
                        fin_neg   = r_neg;
                    end else begin
                        fin_mag = r_neg ? inc_sum : r_work;
                        fin_neg = r_neg;
                    end
                end
                OP_ROUND: begin
                    fin_mag = (r_last_rem >= ROUND_HALF) ? inc_sum : r_work;
                    fin_neg = r_neg;
                end
                default: begin
                    fin_mag = r_work;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ctrl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_op       <= t_op'(i_operation);
            r_neg      <= i_negative;
            r_err      <= in_err;
            r_scale    <= i_scale[SCALE_W-1:0];
            r_orig     <= {i_magnitude_high, i_magnitude_low};
            r_work     <= {i_magnitude_high, i_magnitude_low};
            r_rem      <= '0;
            r_last_rem <= '0;
            r_sticky   <= 1'b0;
            r_digits   <= i_scale[CNT_W-1:0];
            r_limb     <= '0;
        end else if (ctrl.step) begin
            r_work <= {r_work[MAG_W-LIMB_W-1:0], div_quot};
            r_limb <= r_limb + LIMB_CW'(1);
            if (limb_last) begin
                r_rem      <= '0;
                r_last_rem <= div_rem;
                r_sticky   <= r_sticky | (div_rem != '0);
                r_digits   <= r_digits - CNT_W'(1);
            end else begin
                r_rem <= div_rem;
            end
        end
        if (ctrl.finish) begin
            r_res_mag   <= fin_mag;
            r_res_scale <= fin_scale;
            r_res_neg   <= fin_neg;
            r_res_err   <= r_err;
        end
    end

    assign o_busy                  = r_state != S_IDLE;
    assign o_done                  = r_done;
    assign o_result_magnitude_low  = r_res_mag[63:0];
    assign o_result_magnitude_high = r_res_mag[MAG_W-1:64];
    assign o_result_scale          = r_res_scale;
    assign o_result_negative       = r_res_neg;
    assign o_error                 = r_res_err;

    `D128R_CHECK_NEXT(a_start_sets_busy, i_start && !o_busy, o_busy, "transfer did not set busy")
    `D128R_CHECK_NEXT(a_finish_strobes, r_state == S_FIN, o_done && !o_busy, "no result strobe")
    `D128R_CHECK_SAME(a_div_has_digits, r_state == S_DIV, r_digits != '0, "divide without digits")
    `D128R_CHECK_SAME(a_error_zero, o_done && o_error, r_res_mag == '0 && o_result_scale == '0, "error result not zero")

endmodule

### bench/decimal128_integer_rounding_unit_tb.sv
// Self-checking testbench for the decimal128 integer rounding unit.
// Depends on d128r_pkg and the RTL; drives a directed table, then random
// operations, and compares every result with the table or its rounding predictor.
`timescale 1ns / 1ps

module decimal128_integer_rounding_unit_tb import d128r_pkg::*;;

    localparam int          CLK_PERIOD   = 8;
    localparam int          RESET_CYCLES = 6;
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          DRAIN_CYCLES = 120;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam logic [95:0] MAG_MAX      = {96{1'b1}};

    typedef struct packed {
        t_op         op;
        logic [95:0] magnitude;
        logic [7:0]  scale;
        logic        negative;
    } t_operand;

    typedef struct packed {
        logic [95:0] magnitude;
        logic [4:0]  scale;
        logic        negative;
        logic        error;
    } t_rounding_result;

    typedef struct packed {
        t_operand         item;
        logic             typed;
        t_rounding_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_operation;
    logic [63:0] i_magnitude_low;
    logic [31:0] i_magnitude_high;
    logic [7:0]  i_scale;
    logic        i_negative;
    logic        o_done;
    logic [63:0] o_result_magnitude_low;
    logic [31:0] o_result_magnitude_high;
    logic [4:0]  o_result_scale;
    logic        o_result_negative;
    logic        o_error;

    t_rounding_result pending_results[$];
    t_rounding_result want_result;
    t_stim_row        directed_rows[$];
    int               fail_count;
    int               cycle_count;
    int               results_checked;
    int               invalid_scale_results;
    int               items_sent;
    int               op_seen[4];
    int               idle_pct;

    decimal128_integer_rounding_unit uut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_start                 (i_start),
        .o_busy                  (o_busy),
        .i_operation             (i_operation),
        .i_magnitude_low         (i_magnitude_low),
        .i_magnitude_high        (i_magnitude_high),
        .i_scale                 (i_scale),
        .i_negative              (i_negative),
        .o_done                  (o_done),
        .o_result_magnitude_low  (o_result_magnitude_low),
        .o_result_magnitude_high (o_result_magnitude_high),
        .o_result_scale          (o_result_scale),
        .o_result_negative       (o_result_negative),
        .o_error                 (o_error)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_rounding_result predict_rounding(t_operand a);
        t_rounding_result r;
        logic [95:0]      q;
        logic [3:0]       digit;
        logic             sticky;
        r      = '0;
        q      = a.magnitude;
        digit  = '0;
        sticky = 1'b0;
        if (a.scale > MAX_SCALE_DEF) begin
            r.error = 1'b1;
            if (a.op == OP_TRUNCATE) begin
                r.negative = a.negative;
            end else if (a.op == OP_NEGATE) begin
                r.negative = ~a.negative;
            end
        end else if (a.op == OP_NEGATE) begin
            r.magnitude = a.magnitude;
            r.scale     = a.scale[4:0];
            r.negative  = ~a.negative;
        end else begin
            for (int s = 0; s < a.scale; s++) begin
                sticky |= (digit != 0);
                digit   = 4'(q % 10);
                q       = q / 10;
            end
            sticky     |= (digit != 0);
            r.magnitude = q;
            r.negative  = a.negative;
            case (a.op)
                OP_FLOOR: begin
                    if (!sticky) begin
                        r.magnitude = a.magnitude;
                        r.scale     = a.scale[4:0];
                    end else if (a.negative) begin
                        r.magnitude = q + 96'd1;
                    end
                end
                OP_ROUND: begin
                    if (digit >= ROUND_HALF) begin
                        r.magnitude = q + 96'd1;
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_operand random_operand();
        t_operand     a;
        logic [127:0] pow;
        logic [127:0] base;
        logic [127:0] sum;
        logic [95:0]  raw;
        int           kind;
        kind       = $urandom_range(99);
        a.op       = t_op'($urandom_range(3));
        a.negative = 1'($urandom_range(1));
        raw        = {$urandom, $urandom, $urandom};
        if (kind < 8) begin
            a.scale = 8'($urandom_range(255, MAX_SCALE_DEF + 1));
        end else if (kind < 14) begin
            a.scale = 8'(MAX_SCALE_DEF);
        end else if ($urandom_range(3) == 0) begin
            a.scale = 8'($urandom_range(MAX_SCALE_DEF));
        end else begin
            a.scale = 8'($urandom_range(6));
        end
        case ($urandom_range(3))
            0: a.magnitude = raw;
            1: a.magnitude = 96'($urandom_range(1000000));
            2: a.magnitude = raw >> $urandom_range(95);
            default: begin
                pow = 128'd1;
                for (int s = 0; s < a.scale && s < MAX_SCALE_DEF; s++) begin
                    pow = pow * 10;
                end
                base = ({32'd0, raw} % ({32'd0, MAG_MAX} / pow + 1)) * pow;
                case ($urandom_range(3))
                    0: sum = base;
                    1: sum = base + (pow / 10) * 5;
                    2: sum = base + (pow / 10) * 5 - 1;
                    default: sum = base + {32'd0, {$urandom, $urandom, $urandom}} % pow;
                endcase
                a.magnitude = (sum > {32'd0, MAG_MAX}) ? base[95:0] : sum[95:0];
            end
        endcase
        return a;
    endfunction

    task automatic add_row(input t_op op, input logic [95:0] mag, input logic [7:0] sc,
                           input logic neg, input logic typed,
                           input logic [95:0] want_mag, input logic [4:0] want_sc,
                           input logic want_neg, input logic want_err);
        t_stim_row row;
        row.item  = '{op, mag, sc, neg};
        row.typed = typed;
        row.want  = '{want_mag, want_sc, want_neg, want_err};
        directed_rows.push_back(row);
    endtask

    task automatic issue_operation(input t_stim_row row);
        bit accepted;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge i_clk);
            if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                i_start <= 1'b0;
            end else begin
                i_operation      <= row.item.op;
                i_magnitude_low  <= row.item.magnitude[63:0];
                i_magnitude_high <= row.item.magnitude[95:64];
                i_scale          <= row.item.scale;
                i_negative       <= row.item.negative;
                i_start          <= 1'b1;
                @(posedge i_clk);
                if (!o_busy) begin
                    accepted = 1'b1;
                    pending_results.push_back(row.typed ? row.want
                                                        : predict_rounding(row.item));
                    items_sent++;
                    op_seen[row.item.op]++;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [95:0] want,
                               input logic [95:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result transfer with no operation outstanding", $time);
                fail_count++;
            end else begin
                want_result = pending_results.pop_front();
                results_checked++;
                if (want_result.error) begin
                    invalid_scale_results++;
                end
                check_field("result_magnitude_low", 96'(want_result.magnitude[63:0]),
                            96'(o_result_magnitude_low));
                check_field("result_magnitude_high", 96'(want_result.magnitude[95:64]),
                            96'(o_result_magnitude_high));
                check_field("result_scale", 96'(want_result.scale), 96'(o_result_scale));
                check_field("result_negative", 96'(want_result.negative),
                            96'(o_result_negative));
                check_field("error", 96'(want_result.error), 96'(o_error));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        fail_count            = 0;
        cycle_count           = 0;
        results_checked       = 0;
        invalid_scale_results = 0;
        items_sent            = 0;
        op_seen               = '{0, 0, 0, 0};
        idle_pct              = 26;
        i_rst_n               = 1'b0;
        i_start               = 1'b0;
        i_operation           = OP_NEGATE;
        i_magnitude_low       = '0;
        i_magnitude_high      = '0;
        i_scale               = '0;
        i_negative            = 1'b0;

        add_row(OP_NEGATE, MAG_MAX, 8'd0, 1'b0, 1'b1, MAG_MAX, 5'd0, 1'b1, 1'b0);
        add_row(OP_NEGATE, 96'd0, 8'd28, 1'b1, 1'b1, 96'd0, 5'd28, 1'b0, 1'b0);
        add_row(OP_NEGATE, MAG_MAX, 8'd200, 1'b0, 1'b1, 96'd0, 5'd0, 1'b1, 1'b1);
        add_row(OP_NEGATE, 96'd77, 8'd29, 1'b1, 1'b1, 96'd0, 5'd0, 1'b0, 1'b1);
        add_row(OP_TRUNCATE, MAG_MAX, 8'd29, 1'b1, 1'b1, 96'd0, 5'd0, 1'b1, 1'b1);
        add_row(OP_FLOOR, MAG_MAX, 8'd255, 1'b1, 1'b1, 96'd0, 5'd0, 1'b0, 1'b1);
        add_row(OP_ROUND, 96'd12345, 8'd128, 1'b1, 1'b1, 96'd0, 5'd0, 1'b0, 1'b1);
        add_row(OP_TRUNCATE, 96'd0, 8'd5, 1'b1, 1'b1, 96'd0, 5'd0, 1'b1, 1'b0);
        add_row(OP_FLOOR, 96'd1234500, 8'd2, 1'b1, 1'b1, 96'd1234500, 5'd2, 1'b1, 1'b0);
        add_row(OP_TRUNCATE, MAG_MAX, 8'd28, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_TRUNCATE, MAG_MAX, 8'd0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_FLOOR, 96'd12345, 8'd2, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_FLOOR, 96'd12345, 8'd2, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_FLOOR, 96'd1000001, 8'd6, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_FLOOR, MAG_MAX, 8'd1, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_FLOOR, MAG_MAX, 8'd0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_ROUND, 96'd125, 8'd1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_ROUND, 96'd124, 8'd1, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_ROUND, 96'd4, 8'd1, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_ROUND, 96'd5, 8'd1, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_ROUND, 96'd149, 8'd2, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(OP_ROUND, 96'd5000000000000000000000000000, 8'd28, 1'b0, 1'b0,
                '0, '0, 1'b0, 1'b0);
        add_row(OP_ROUND, MAG_MAX, 8'd28, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            issue_operation(directed_rows[k]);
        end

        row.typed = 1'b0;
        row.want  = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                idle_pct = 85;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                idle_pct = 0;
            end
            row.item = random_operand();
            issue_operation(row);
        end
        @(negedge i_clk);
        i_start <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d operations: %0d negate, %0d truncate, %0d floor, %0d round.",
                 items_sent, op_seen[OP_NEGATE], op_seen[OP_TRUNCATE],
                 op_seen[OP_FLOOR], op_seen[OP_ROUND]);
        $display("Compared %0d results, %0d of them with an invalid scale; %0d mismatches.",
                 results_checked, invalid_scale_results, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
